[rtl/letterbox_bilinear_image_resizer_defines.svh]
// Assertion macros shared by the letterbox resizer RTL.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef LETTERBOX_BILINEAR_IMAGE_RESIZER_DEFINES_SVH
`define LETTERBOX_BILINEAR_IMAGE_RESIZER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LBR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define LBR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/lbr_pkg.sv]
// Shared types and constants of the letterbox bilinear resizer.
// No dependencies; used by the top level by scoped names.
`timescale 1ns / 1ps

package lbr_pkg;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PAD_VALUE  = 3'd4;

  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned SIZE_REG_W = 11;
  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned COORD_W    = 10;
  localparam int unsigned PIXEL_W    = 3 * CHAN_W;

  // Reset values of the configuration registers.
  localparam logic [SIZE_REG_W-1:0] SIZE_RESET = 11'd640;
  localparam logic [CHAN_W-1:0]     PAD_RESET  = 8'd114;

  // Request types.
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  // Sequencer states.
  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_CMP   = 13'b0000000000010,
    S_DIV1  = 13'b0000000000100,
    S_DIV2  = 13'b0000000001000,
    S_PAD   = 13'b0000000010000,
    S_MULX  = 13'b0000000100000,
    S_MAPX  = 13'b0000001000000,
    S_MULY  = 13'b0000010000000,
    S_MAPY  = 13'b0000100000000,
    S_FETCH = 13'b0001000000000,
    S_HOR   = 13'b0010000000000,
    S_VER   = 13'b0100000000000,
    S_DONE  = 13'b1000000000000
  } state_t;

endpackage

[rtl/lbr_ram.sv]
// Generic single-port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lbr_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One access per cycle: write or registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[rtl/letterbox_bilinear_image_resizer.sv]
// Letterbox bilinear resizer: a source RGB frame store and a sequencer
// that answers canvas pixel reads. Depends on lbr_pkg, lbr_ram and the
// assertion macro header.
//
// Usage:
//   The input channel (in_valid/in_ready) carries one request per transfer.
//   A write request stores one source pixel; a read request asks for one
//   canvas pixel. Every request yields exactly one transfer on the output
//   channel (out_valid/out_ready). Out-of-range coordinates set
//   out_bad_coord; border pixels return pad_value with out_in_padding set.
//   The block works on one request at a time. A write or an out-of-range
//   read raises out_valid in the cycle after its transfer. For a read
//   inside the canvas, the bit-serial divider computes the scaled size and
//   the inverse scale one quotient bit per cycle, then the single frame
//   memory port fetches four texels one per cycle. Border reads end before
//   the texel fetch. in_ready is high only while the block is idle, which it
//   is again in the cycle after the output transfer. Results stay on the
//   output registers until the receiver takes them; a stalled receiver
//   holds the block. Synchronous reset returns the configuration and
//   control registers to their defaults; frame contents are undefined until
//   written. Configuration writes (cfg_wr_en) take effect at once and must
//   only be issued while the block is idle.
`timescale 1ns / 1ps
`include "letterbox_bilinear_image_resizer_defines.svh"

module letterbox_bilinear_image_resizer #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [lbr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lbr_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_req_type,
  input  logic [lbr_pkg::COORD_W-1:0]      in_coord_x,
  input  logic [lbr_pkg::COORD_W-1:0]      in_coord_y,
  input  logic [lbr_pkg::CHAN_W-1:0]       in_red,
  input  logic [lbr_pkg::CHAN_W-1:0]       in_green,
  input  logic [lbr_pkg::CHAN_W-1:0]       in_blue,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [lbr_pkg::CHAN_W-1:0]       out_red,
  output logic [lbr_pkg::CHAN_W-1:0]       out_green,
  output logic [lbr_pkg::CHAN_W-1:0]       out_blue,
  output logic                             out_in_padding,
  output logic                             out_bad_coord
);

  localparam int unsigned MAXS  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int unsigned SZW   = $clog2(MAXS + 1);
  localparam int unsigned IVW   = SZW + FRAC_BITS;
  localparam int unsigned DNW   = (2 * SZW > IVW) ? 2 * SZW : IVW;
  localparam int unsigned DCW   = $clog2(DNW + 1);
  localparam int unsigned PMW   = SZW + 1 + IVW;
  localparam int unsigned NMW   = PMW - 1;
  localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned WW    = FRAC_BITS + 1;
  localparam int unsigned HPW   = lbr_pkg::CHAN_W + WW;
  localparam int unsigned TPW   = lbr_pkg::CHAN_W + FRAC_BITS;
  localparam int unsigned VW    = TPW + WW;
  localparam int unsigned CW    = lbr_pkg::CHAN_W;
  localparam int unsigned PXW   = lbr_pkg::PIXEL_W;

  // Configuration registers.
  logic [lbr_pkg::SIZE_REG_W-1:0] src_w_r, src_h_r, dst_w_r, dst_h_r;
  logic [CW-1:0]                  pad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r <= lbr_pkg::SIZE_RESET;
      src_h_r <= lbr_pkg::SIZE_RESET;
      dst_w_r <= lbr_pkg::SIZE_RESET;
      dst_h_r <= lbr_pkg::SIZE_RESET;
      pad_r   <= lbr_pkg::PAD_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        lbr_pkg::CFG_SRC_WIDTH:  src_w_r <= cfg_wdata;
        lbr_pkg::CFG_SRC_HEIGHT: src_h_r <= cfg_wdata;
        lbr_pkg::CFG_DST_WIDTH:  dst_w_r <= cfg_wdata;
        lbr_pkg::CFG_DST_HEIGHT: dst_h_r <= cfg_wdata;
        lbr_pkg::CFG_PAD_VALUE:  pad_r   <= cfg_wdata[CW-1:0];
        default: ;
      endcase
    end
  end

  // Effective sizes: zero reads as one, large values saturate to the maximum.
  logic [SZW-1:0] sw, sh, dw, dh;

  always_comb begin
    if (src_w_r == '0) sw = SZW'(1);
    else if (32'(src_w_r) > MAX_WIDTH) sw = SZW'(MAX_WIDTH);
    else sw = SZW'(src_w_r);
    if (src_h_r == '0) sh = SZW'(1);
    else if (32'(src_h_r) > MAX_HEIGHT) sh = SZW'(MAX_HEIGHT);
    else sh = SZW'(src_h_r);
    if (dst_w_r == '0) dw = SZW'(1);
    else if (32'(dst_w_r) > MAX_WIDTH) dw = SZW'(MAX_WIDTH);
    else dw = SZW'(dst_w_r);
    if (dst_h_r == '0) dh = SZW'(1);
    else if (32'(dst_h_r) > MAX_HEIGHT) dh = SZW'(MAX_HEIGHT);
    else dh = SZW'(dst_h_r);
  end

  // Sequencer and datapath registers.
  lbr_pkg::state_t      state_r, state_nxt;
  logic [lbr_pkg::COORD_W-1:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic                 limw_r, limw_nxt;
  logic [DNW-1:0]       dnum_r, dnum_nxt, quo_r, quo_nxt;
  logic [SZW-1:0]       dden_r, dden_nxt;
  logic [SZW:0]         rem_r, rem_nxt;
  logic [DCW-1:0]       dcnt_r, dcnt_nxt;
  logic [SZW-1:0]       scl_r, scl_nxt;
  logic [IVW-1:0]       inv_r, inv_nxt;
  logic [SZW-1:0]       dx_r, dx_nxt, dy_r, dy_nxt;
  logic [NMW-1:0]       num_r, num_nxt;
  logic [SZW-1:0]       x0_r, x0_nxt, x1_r, x1_nxt, y0_r, y0_nxt, y1_r, y1_nxt;
  logic [FRAC_BITS-1:0] fx_r, fx_nxt, fy_r, fy_nxt;
  logic [2:0]           fcnt_r, fcnt_nxt;
  logic [PXW-1:0]       tex_r [4];
  logic [PXW-1:0]       tex_nxt [4];
  logic [1:0]           ch_r, ch_nxt;
  logic [TPW-1:0]       top_r, top_nxt, bot_r, bot_nxt;
  logic [CW-1:0]        ored_r, ored_nxt, ogrn_r, ogrn_nxt, oblu_r, oblu_nxt;
  logic                 opad_r, opad_nxt, obad_r, obad_nxt;

  // Frame memory port.
  logic           ram_we;
  logic [AW-1:0]  ram_addr;
  logic [PXW-1:0] ram_wdata, ram_rdata;

  lbr_ram #(.WIDTH(PXW), .DEPTH(DEPTH)) u_frame (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Shared divider step: one quotient bit per cycle.
  logic [SZW:0]   rem_s, rem_step;
  logic           div_ge;
  logic [DNW-1:0] quo_step;

  always_comb begin
    rem_s    = {rem_r[SZW-1:0], dnum_r[DNW-1]};
    div_ge   = rem_s >= {1'b0, dden_r};
    rem_step = div_ge ? (rem_s - {1'b0, dden_r}) : rem_s;
    quo_step = {quo_r[DNW-2:0], div_ge};
  end

  // Shared coordinate multiplier: (2d + 1) * inv, halved.
  logic [SZW-1:0] map_d;
  logic [PMW-1:0] map_prod;

  always_comb begin
    map_d    = state_r == lbr_pkg::S_MULY ? dy_r : dx_r;
    map_prod = PMW'({map_d, 1'b1}) * PMW'(inv_r);
  end

  // Tap and fraction extraction from the registered product.
  logic [NMW-1:0]       half_c, m_v, lo_v, hi_v, szm1_v;
  logic [FRAC_BITS-1:0] f_v;
  logic [SZW-1:0]       tap0_v, tap1_v;

  always_comb begin
    half_c = NMW'(1) << (FRAC_BITS - 1);
    szm1_v = NMW'(state_r == lbr_pkg::S_MAPY ? sh : sw) - NMW'(1);
    m_v    = num_r - half_c;
    if (num_r >= half_c) begin
      lo_v = m_v >> FRAC_BITS;
      hi_v = lo_v + NMW'(1);
      f_v  = m_v[FRAC_BITS-1:0];
    end else begin
      lo_v = '0;
      hi_v = '0;
      f_v  = FRAC_BITS'(num_r + half_c);
    end
    tap0_v = (lo_v > szm1_v) ? SZW'(szm1_v) : SZW'(lo_v);
    tap1_v = (hi_v > szm1_v) ? SZW'(szm1_v) : SZW'(hi_v);
  end

  // Blend arithmetic for the current channel.
  logic [CW-1:0]  ta, tb, tc, td;
  logic [WW-1:0]  one_c, omfx, omfy;
  logic [VW-1:0]  vsum;
  logic [VW-2*FRAC_BITS-1:0] vint;
  logic [CW-1:0]  vsat;
  logic [TPW-1:0] hor_top, hor_bot;

  always_comb begin
    case (ch_r)
      2'd0: begin
        ta = tex_r[0][23:16]; tb = tex_r[1][23:16];
        tc = tex_r[2][23:16]; td = tex_r[3][23:16];
      end
      2'd1: begin
        ta = tex_r[0][15:8]; tb = tex_r[1][15:8];
        tc = tex_r[2][15:8]; td = tex_r[3][15:8];
      end
      default: begin
        ta = tex_r[0][7:0]; tb = tex_r[1][7:0];
        tc = tex_r[2][7:0]; td = tex_r[3][7:0];
      end
    endcase
    one_c   = WW'(1) << FRAC_BITS;
    omfx    = one_c - WW'(fx_r);
    omfy    = one_c - WW'(fy_r);
    hor_top = TPW'(HPW'(ta) * HPW'(omfx) + HPW'(tb) * HPW'(fx_r));
    hor_bot = TPW'(HPW'(tc) * HPW'(omfx) + HPW'(td) * HPW'(fx_r));
    vsum    = VW'(top_r) * VW'(omfy) + VW'(bot_r) * VW'(fy_r);
    vint    = vsum[VW-1:2*FRAC_BITS];
    vsat    = (vint > (VW-2*FRAC_BITS)'(255)) ? CW'(255) : CW'(vint);
  end

  // Geometry helpers for the comparison and the border test.
  logic [2*SZW-1:0] pa_v, pb_v;
  logic             limw_v;
  logic [31:0]      nw_v, nh_v, pl_v, pt_v;
  logic             pad_hit;
  logic             acc;

  always_comb begin
    pa_v    = (2*SZW)'(dw) * (2*SZW)'(sh);
    pb_v    = (2*SZW)'(dh) * (2*SZW)'(sw);
    limw_v  = pa_v <= pb_v;
    nw_v    = limw_r ? 32'(dw) : 32'(scl_r);
    nh_v    = limw_r ? 32'(scl_r) : 32'(dh);
    pl_v    = (32'(dw) - nw_v) >> 1;
    pt_v    = (32'(dh) - nh_v) >> 1;
    pad_hit = (32'(cx_r) < pl_v) || (32'(cx_r) >= pl_v + nw_v) ||
              (32'(cy_r) < pt_v) || (32'(cy_r) >= pt_v + nh_v);
    acc     = in_valid && in_ready;
  end

  // Sequencer next-state and datapath updates.
  always_comb begin
    state_nxt = state_r;
    cx_nxt = cx_r;     cy_nxt = cy_r;
    limw_nxt = limw_r; dnum_nxt = dnum_r; quo_nxt = quo_r;
    dden_nxt = dden_r; rem_nxt = rem_r;   dcnt_nxt = dcnt_r;
    scl_nxt = scl_r;   inv_nxt = inv_r;
    dx_nxt = dx_r;     dy_nxt = dy_r;     num_nxt = num_r;
    x0_nxt = x0_r;     x1_nxt = x1_r;     y0_nxt = y0_r; y1_nxt = y1_r;
    fx_nxt = fx_r;     fy_nxt = fy_r;     fcnt_nxt = fcnt_r;
    for (int i = 0; i < 4; i++) tex_nxt[i] = tex_r[i];
    ch_nxt = ch_r;     top_nxt = top_r;   bot_nxt = bot_r;
    ored_nxt = ored_r; ogrn_nxt = ogrn_r; oblu_nxt = oblu_r;
    opad_nxt = opad_r; obad_nxt = obad_r;
    ram_we    = 1'b0;
    ram_wdata = {in_red, in_green, in_blue};
    ram_addr  = AW'(32'(in_coord_y) * MAX_WIDTH + 32'(in_coord_x));

    case (state_r)
      lbr_pkg::S_IDLE: begin
        if (acc) begin
          cx_nxt = in_coord_x;
          cy_nxt = in_coord_y;
          ored_nxt = '0; ogrn_nxt = '0; oblu_nxt = '0;
          opad_nxt = 1'b0; obad_nxt = 1'b0;
          if (in_req_type == lbr_pkg::REQ_WRITE) begin
            if (32'(in_coord_x) >= 32'(sw) || 32'(in_coord_y) >= 32'(sh)) begin
              obad_nxt = 1'b1;
            end else begin
              ram_we = 1'b1;
            end
            state_nxt = lbr_pkg::S_DONE;
          end else if (32'(in_coord_x) >= 32'(dw) || 32'(in_coord_y) >= 32'(dh)) begin
            obad_nxt  = 1'b1;
            state_nxt = lbr_pkg::S_DONE;
          end else begin
            state_nxt = lbr_pkg::S_CMP;
          end
        end
      end
      lbr_pkg::S_CMP: begin
        // Pick the limiting axis and start the scaled-size division.
        limw_nxt  = limw_v;
        dnum_nxt  = DNW'(limw_v ? pa_v : pb_v);
        dden_nxt  = limw_v ? sw : sh;
        rem_nxt   = '0;
        quo_nxt   = '0;
        dcnt_nxt  = '0;
        state_nxt = lbr_pkg::S_DIV1;
      end
      lbr_pkg::S_DIV1: begin
        rem_nxt  = rem_step;
        quo_nxt  = quo_step;
        dnum_nxt = dnum_r << 1;
        dcnt_nxt = dcnt_r + DCW'(1);
        if (dcnt_r == DCW'(DNW - 1)) begin
          // Scaled size done; start the inverse scale division.
          scl_nxt   = SZW'(quo_step);
          dnum_nxt  = DNW'(limw_r ? sw : sh) << FRAC_BITS;
          dden_nxt  = limw_r ? dw : dh;
          rem_nxt   = '0;
          quo_nxt   = '0;
          dcnt_nxt  = '0;
          state_nxt = lbr_pkg::S_DIV2;
        end
      end
      lbr_pkg::S_DIV2: begin
        rem_nxt  = rem_step;
        quo_nxt  = quo_step;
        dnum_nxt = dnum_r << 1;
        dcnt_nxt = dcnt_r + DCW'(1);
        if (dcnt_r == DCW'(DNW - 1)) begin
          inv_nxt   = IVW'(quo_step);
          state_nxt = lbr_pkg::S_PAD;
        end
      end
      lbr_pkg::S_PAD: begin
        if (pad_hit) begin
          ored_nxt  = pad_r;
          ogrn_nxt  = pad_r;
          oblu_nxt  = pad_r;
          opad_nxt  = 1'b1;
          state_nxt = lbr_pkg::S_DONE;
        end else begin
          dx_nxt    = SZW'(32'(cx_r) - pl_v);
          dy_nxt    = SZW'(32'(cy_r) - pt_v);
          state_nxt = lbr_pkg::S_MULX;
        end
      end
      lbr_pkg::S_MULX: begin
        num_nxt   = NMW'(map_prod >> 1);
        state_nxt = lbr_pkg::S_MAPX;
      end
      lbr_pkg::S_MAPX: begin
        x0_nxt    = tap0_v;
        x1_nxt    = tap1_v;
        fx_nxt    = f_v;
        state_nxt = lbr_pkg::S_MULY;
      end
      lbr_pkg::S_MULY: begin
        num_nxt   = NMW'(map_prod >> 1);
        state_nxt = lbr_pkg::S_MAPY;
      end
      lbr_pkg::S_MAPY: begin
        y0_nxt    = tap0_v;
        y1_nxt    = tap1_v;
        fy_nxt    = f_v;
        fcnt_nxt  = '0;
        state_nxt = lbr_pkg::S_FETCH;
      end
      lbr_pkg::S_FETCH: begin
        // Issue one texel address per cycle; the read data returns in the cycle after its address.
        case (fcnt_r)
          3'd0: ram_addr = AW'(32'(y0_r) * MAX_WIDTH + 32'(x0_r));
          3'd1: ram_addr = AW'(32'(y0_r) * MAX_WIDTH + 32'(x1_r));
          3'd2: ram_addr = AW'(32'(y1_r) * MAX_WIDTH + 32'(x0_r));
          default: ram_addr = AW'(32'(y1_r) * MAX_WIDTH + 32'(x1_r));
        endcase
        if (fcnt_r != 3'd0) begin
          tex_nxt[2'(fcnt_r - 3'd1)] = ram_rdata;
        end
        fcnt_nxt = fcnt_r + 3'd1;
        if (fcnt_r == 3'd4) begin
          ch_nxt    = '0;
          state_nxt = lbr_pkg::S_HOR;
        end
      end
      lbr_pkg::S_HOR: begin
        top_nxt   = hor_top;
        bot_nxt   = hor_bot;
        state_nxt = lbr_pkg::S_VER;
      end
      lbr_pkg::S_VER: begin
        case (ch_r)
          2'd0:    ored_nxt = vsat;
          2'd1:    ogrn_nxt = vsat;
          default: oblu_nxt = vsat;
        endcase
        ch_nxt = ch_r + 2'd1;
        if (ch_r == 2'd2) state_nxt = lbr_pkg::S_DONE;
        else              state_nxt = lbr_pkg::S_HOR;
      end
      lbr_pkg::S_DONE: begin
        if (out_ready) state_nxt = lbr_pkg::S_IDLE;
      end
      default: state_nxt = lbr_pkg::S_IDLE;
    endcase
  end

  // Control registers take reset; payload registers do not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lbr_pkg::S_IDLE;
      dcnt_r  <= '0;
      fcnt_r  <= '0;
      ch_r    <= '0;
    end else begin
      state_r <= state_nxt;
      dcnt_r  <= dcnt_nxt;
      fcnt_r  <= fcnt_nxt;
      ch_r    <= ch_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cx_r <= cx_nxt;     cy_r <= cy_nxt;
    limw_r <= limw_nxt; dnum_r <= dnum_nxt; quo_r <= quo_nxt;
    dden_r <= dden_nxt; rem_r <= rem_nxt;
    scl_r <= scl_nxt;   inv_r <= inv_nxt;
    dx_r <= dx_nxt;     dy_r <= dy_nxt;     num_r <= num_nxt;
    x0_r <= x0_nxt;     x1_r <= x1_nxt;     y0_r <= y0_nxt; y1_r <= y1_nxt;
    fx_r <= fx_nxt;     fy_r <= fy_nxt;
    for (int i = 0; i < 4; i++) tex_r[i] <= tex_nxt[i];
    top_r <= top_nxt;   bot_r <= bot_nxt;
    ored_r <= ored_nxt; ogrn_r <= ogrn_nxt; oblu_r <= oblu_nxt;
    opad_r <= opad_nxt; obad_r <= obad_nxt;
  end

  // Port drive.
  assign in_ready       = state_r == lbr_pkg::S_IDLE;
  assign out_valid      = state_r == lbr_pkg::S_DONE;
  assign out_red        = ored_r;
  assign out_green      = ogrn_r;
  assign out_blue       = oblu_r;
  assign out_in_padding = opad_r;
  assign out_bad_coord  = obad_r;

  // Checks on the sequencer.
  `LBR_ASSERT_IMP(a_one_item, in_ready, !out_valid, "accepting while a result is held")
  `LBR_ASSERT_NXT(a_write_done, acc && in_req_type == lbr_pkg::REQ_WRITE, out_valid, "write result late")
  `LBR_ASSERT_IMP(a_bad_clean, out_valid && out_bad_coord, !out_in_padding && out_red == '0, "bad coordinate result not cleared")
  `LBR_ASSERT_IMP(a_div_bound, state_r == lbr_pkg::S_DIV1 || state_r == lbr_pkg::S_DIV2, dcnt_r < DCW'(DNW), "divider overran")

endmodule

[sim/letterbox_bilinear_image_resizer_tb.sv]
// Self-checking testbench for letterbox_bilinear_image_resizer: random and directed
// pixel writes, canvas reads and register settings, checked against a built-in predictor.
// Depends on lbr_pkg and the resizer RTL only.
`timescale 1ns / 1ps

typedef struct {
  logic       req_type;
  logic [9:0] x;
  logic [9:0] y;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
} pixel_req_t;

typedef struct {
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       in_padding;
  logic       bad_coord;
} pixel_res_t;

// Holds the register copy, the source frame copy and the queue of expected pixels.
class resize_scoreboard;
  localparam int unsigned FRAC   = 16;
  localparam int unsigned MAXDIM = 1024;

  logic [10:0] src_w_reg, src_h_reg, dst_w_reg, dst_h_reg;
  logic [7:0]  pad_reg;
  logic [23:0] frame_copy[int unsigned];
  pixel_res_t  expected_px[$];
  int          errors;

  function new();
    src_w_reg = 11'd640;
    src_h_reg = 11'd640;
    dst_w_reg = 11'd640;
    dst_h_reg = 11'd640;
    pad_reg   = 8'd114;
    errors    = 0;
  endfunction

  function void set_reg(logic [2:0] idx, logic [10:0] data);
    case (idx)
      lbr_pkg::CFG_SRC_WIDTH:  src_w_reg = data;
      lbr_pkg::CFG_SRC_HEIGHT: src_h_reg = data;
      lbr_pkg::CFG_DST_WIDTH:  dst_w_reg = data;
      lbr_pkg::CFG_DST_HEIGHT: dst_h_reg = data;
      lbr_pkg::CFG_PAD_VALUE:  pad_reg = data[7:0];
      default: ;
    endcase
  endfunction

  // Zero counts as one and oversize saturates to the frame limit.
  function longint unsigned eff(logic [10:0] v);
    if (v == 0) return 1;
    if (v > MAXDIM) return MAXDIM;
    return v;
  endfunction

  // Half-pixel-centre mapping of a canvas-local index onto two source taps.
  function void map_axis(longint unsigned d, longint unsigned inv, longint unsigned size,
                         output longint unsigned t0, output longint unsigned t1,
                         output longint unsigned f);
    longint unsigned num, m;
    num = ((2 * d + 1) * inv) >> 1;
    if (num >= (64'd1 << (FRAC - 1))) begin
      m  = num - (64'd1 << (FRAC - 1));
      t0 = m >> FRAC;
      f  = m & ((64'd1 << FRAC) - 1);
      t1 = t0 + 1;
    end else begin
      t0 = 0;
      t1 = 0;
      f  = num + (64'd1 << (FRAC - 1));
    end
    if (t0 > size - 1) t0 = size - 1;
    if (t1 > size - 1) t1 = size - 1;
  endfunction

  // Works out the pixel for one request; safe is low when a tap was never written.
  function void predict(pixel_req_t r, output pixel_res_t e, output bit safe);
    longint unsigned sw, sh, dw, dh, nw, nh, inv, pl, pt;
    longint unsigned x0, x1, fx, y0, y1, fy, one, top, bot, v;
    logic [23:0] p00, p10, p01, p11;
    int unsigned a00, a10, a01, a11;
    sw = eff(src_w_reg);
    sh = eff(src_h_reg);
    dw = eff(dst_w_reg);
    dh = eff(dst_h_reg);
    one = 64'd1 << FRAC;
    e = '{8'd0, 8'd0, 8'd0, 1'b0, 1'b0};
    safe = 1'b1;
    if (r.req_type == lbr_pkg::REQ_WRITE) begin
      if (r.x >= sw || r.y >= sh) e.bad_coord = 1'b1;
      return;
    end
    if (r.x >= dw || r.y >= dh) begin
      e.bad_coord = 1'b1;
      return;
    end
    if (dw * sh <= dh * sw) begin
      nw = dw;
      nh = (sh * dw) / sw;
      inv = (sw << FRAC) / dw;
    end else begin
      nh = dh;
      nw = (sw * dh) / sh;
      inv = (sh << FRAC) / dh;
    end
    pl = (dw - nw) / 2;
    pt = (dh - nh) / 2;
    if (r.x < pl || r.x >= pl + nw || r.y < pt || r.y >= pt + nh) begin
      e = '{pad_reg, pad_reg, pad_reg, 1'b1, 1'b0};
      return;
    end
    map_axis(r.x - pl, inv, sw, x0, x1, fx);
    map_axis(r.y - pt, inv, sh, y0, y1, fy);
    a00 = 32'(y0 * MAXDIM + x0);
    a10 = 32'(y0 * MAXDIM + x1);
    a01 = 32'(y1 * MAXDIM + x0);
    a11 = 32'(y1 * MAXDIM + x1);
    if (!frame_copy.exists(a00) || !frame_copy.exists(a10) ||
        !frame_copy.exists(a01) || !frame_copy.exists(a11)) begin
      safe = 1'b0;
      return;
    end
    p00 = frame_copy[a00];
    p10 = frame_copy[a10];
    p01 = frame_copy[a01];
    p11 = frame_copy[a11];
    for (int c = 0; c < 3; c++) begin
      top = p00[16 - 8 * c +: 8] * (one - fx) + p10[16 - 8 * c +: 8] * fx;
      bot = p01[16 - 8 * c +: 8] * (one - fx) + p11[16 - 8 * c +: 8] * fx;
      v = (top * (one - fy) + bot * fy) >> (2 * FRAC);
      if (v > 255) v = 255;
      case (c)
        0: e.red = v[7:0];
        1: e.green = v[7:0];
        default: e.blue = v[7:0];
      endcase
    end
  endfunction

  // Called for every input transfer: queues the expected pixel and updates the frame.
  function void note_request(pixel_req_t r);
    pixel_res_t e;
    bit safe;
    predict(r, e, safe);
    expected_px.push_back(e);
    if (r.req_type == lbr_pkg::REQ_WRITE && !e.bad_coord)
      frame_copy[r.y * MAXDIM + r.x] = {r.red, r.green, r.blue};
  endfunction

  // Called for every output transfer.
  function void check_result(pixel_res_t got);
    pixel_res_t e;
    bit bad;
    bad = 1'b0;
    if (expected_px.size() == 0) begin
      $display("%0t: unexpected result %p", $time, got);
      errors++;
      return;
    end
    e = expected_px.pop_front();
    if (got.red !== e.red) begin
      $display("%0t: red expected %0d actual %0d", $time, e.red, got.red);
      bad = 1'b1;
    end
    if (got.green !== e.green) begin
      $display("%0t: green expected %0d actual %0d", $time, e.green, got.green);
      bad = 1'b1;
    end
    if (got.blue !== e.blue) begin
      $display("%0t: blue expected %0d actual %0d", $time, e.blue, got.blue);
      bad = 1'b1;
    end
    if (got.in_padding !== e.in_padding) begin
      $display("%0t: in_padding expected %0b actual %0b", $time, e.in_padding,
               got.in_padding);
      bad = 1'b1;
    end
    if (got.bad_coord !== e.bad_coord) begin
      $display("%0t: bad_coord expected %0b actual %0b", $time, e.bad_coord, got.bad_coord);
      bad = 1'b1;
    end
    if (bad) errors++;
  endfunction
endclass

module letterbox_bilinear_image_resizer_tb;

  localparam logic [lbr_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
  localparam int unsigned TARGET_ITEMS = 1250;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [lbr_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [lbr_pkg::CFG_DATA_W-1:0] cfg_wdata;
  logic in_valid, in_ready, in_req_type;
  logic [lbr_pkg::COORD_W-1:0] in_coord_x, in_coord_y;
  logic [lbr_pkg::CHAN_W-1:0] in_red, in_green, in_blue;
  logic out_valid, out_ready;
  logic [lbr_pkg::CHAN_W-1:0] out_red, out_green, out_blue;
  logic out_in_padding, out_bad_coord;

  resize_scoreboard sb = new();
  int unsigned sent_count = 0;
  int unsigned result_count = 0;

  letterbox_bilinear_image_resizer i_dut (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Run limit far above the slowest correct run.
  initial begin
    #40ms;
    $display("letterbox_bilinear_image_resizer regression: fail");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (roll < 12) return 0;
    if (roll < 19) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offers one request and waits for its transfer; leaves valid high without a gap.
  task automatic send_req(pixel_req_t r);
    int unsigned gap;
    @(negedge clk);
    in_valid    <= 1'b1;
    in_req_type <= r.req_type;
    in_coord_x  <= r.x;
    in_coord_y  <= r.y;
    in_red      <= r.red;
    in_green    <= r.green;
    in_blue     <= r.blue;
    do @(posedge clk); while (!in_ready);
    sb.note_request(r);
    sent_count++;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic write_reg(logic [lbr_pkg::CFG_IDX_W-1:0] idx,
                           logic [lbr_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    sb.set_reg(idx, data);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Lets the block drain before a register change.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.expected_px.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_sizes(logic [10:0] sw, logic [10:0] sh, logic [10:0] dw,
                           logic [10:0] dh, logic [7:0] pad);
    drain();
    write_reg(lbr_pkg::CFG_SRC_WIDTH, sw);
    write_reg(lbr_pkg::CFG_SRC_HEIGHT, sh);
    write_reg(lbr_pkg::CFG_DST_WIDTH, dw);
    write_reg(lbr_pkg::CFG_DST_HEIGHT, dh);
    write_reg(lbr_pkg::CFG_PAD_VALUE, {3'b000, pad});
  endtask

  function automatic pixel_req_t make_req(logic t, int unsigned x, int unsigned y);
    make_req = '{t, x[9:0], y[9:0], 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))};
  endfunction

  function automatic logic [10:0] pick_src_size();
    case ($urandom_range(0, 5))
      0: return 11'd0;
      1: return 11'd2047;
      2: return 11'd1024;
      3: return 11'd1;
      default: return 11'($urandom_range(1, 16));
    endcase
  endfunction

  function automatic logic [10:0] pick_dst_size();
    case ($urandom_range(0, 6))
      0: return 11'd0;
      1: return 11'd2047;
      2: return 11'd1024;
      3: return 11'd1;
      4: return 11'($urandom_range(1, 1024));
      default: return 11'($urandom_range(1, 64));
    endcase
  endfunction

  // Loads the top-left corner of the source so that reads have texels to blend.
  task automatic fill_source();
    int unsigned fw, fh;
    fw = 32'(sb.eff(sb.src_w_reg) > 12 ? 12 : sb.eff(sb.src_w_reg));
    fh = 32'(sb.eff(sb.src_h_reg) > 12 ? 12 : sb.eff(sb.src_h_reg));
    for (int unsigned y = 0; y < fh; y++)
      for (int unsigned x = 0; x < fw; x++)
        send_req(make_req(lbr_pkg::REQ_WRITE, x, y));
  endtask

  // Random mix of reads and writes; reads that would touch unwritten texels are redrawn.
  task automatic random_traffic(int unsigned n);
    pixel_req_t r;
    pixel_res_t e;
    bit safe;
    int unsigned lim;
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        if ($urandom_range(0, 2) == 0)
          r = make_req(lbr_pkg::REQ_WRITE, $urandom_range(0, 1023), $urandom_range(0, 1023));
        else
          r = make_req(lbr_pkg::REQ_WRITE, $urandom_range(0, 15), $urandom_range(0, 15));
        send_req(r);
      end else begin
        safe = 1'b0;
        for (int k = 0; k < 40 && !safe; k++) begin
          if ($urandom_range(0, 4) < 2) begin
            r = make_req(lbr_pkg::REQ_READ, $urandom_range(0, 1023), $urandom_range(0, 1023));
          end else begin
            lim = 32'(sb.eff(sb.dst_w_reg) > 48 ? 48 : sb.eff(sb.dst_w_reg));
            r = make_req(lbr_pkg::REQ_READ, $urandom_range(0, lim - 1), 0);
            lim = 32'(sb.eff(sb.dst_h_reg) > 48 ? 48 : sb.eff(sb.dst_h_reg));
            r.y = 10'($urandom_range(0, lim - 1));
          end
          sb.predict(r, e, safe);
        end
        if (safe) send_req(r);
      end
    end
  endtask

  // Receiver: random stalls, plus one long hold-off that backs up the input.
  initial begin
    int unsigned stall_left;
    bit long_done;
    pixel_res_t got;
    stall_left = 0;
    long_done  = 1'b0;
    out_ready  = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        got = '{out_red, out_green, out_blue, out_in_padding, out_bad_coord};
        sb.check_result(got);
        result_count++;
      end
      @(negedge clk);
      if (stall_left == 0) begin
        if (!long_done && result_count >= 60) begin
          long_done  = 1'b1;
          stall_left = 400;
        end else begin
          stall_left = pick_gap();
        end
        out_ready <= (stall_left == 0);
      end else begin
        stall_left--;
        out_ready <= (stall_left == 0);
      end
    end
  end

  // Stimulus.
  initial begin
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_index   = lbr_pkg::CFG_SRC_WIDTH;
    cfg_wdata   = '0;
    in_valid    = 1'b0;
    in_req_type = lbr_pkg::REQ_WRITE;
    in_coord_x  = '0;
    in_coord_y  = '0;
    in_red      = '0;
    in_green    = '0;
    in_blue     = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: a 4x2 source letterboxed onto an 8x8 canvas with a zero border value.
    set_sizes(11'd4, 11'd2, 11'd8, 11'd8, 8'd0);
    write_reg(CFG_UNUSED, 11'h7FF);
    for (int unsigned y = 0; y < 2; y++)
      for (int unsigned x = 0; x < 4; x++)
        send_req('{lbr_pkg::REQ_WRITE, x[9:0], y[9:0], ((x + y) % 2) ? 8'hFF : 8'h00,
                   (x % 2) ? 8'h00 : 8'hFF, 8'hFF * y[0]});
    send_req('{lbr_pkg::REQ_WRITE, 10'd1023, 10'd1023, 8'hFF, 8'hFF, 8'hFF});
    send_req('{lbr_pkg::REQ_WRITE, 10'd4, 10'd0, 8'h55, 8'hAA, 8'h55});
    send_req('{lbr_pkg::REQ_READ, 10'd0, 10'd0, 8'h00, 8'h00, 8'h00});
    send_req('{lbr_pkg::REQ_READ, 10'd7, 10'd7, 8'h00, 8'h00, 8'h00});
    send_req('{lbr_pkg::REQ_READ, 10'd8, 10'd0, 8'h00, 8'h00, 8'h00});
    send_req('{lbr_pkg::REQ_READ, 10'd0, 10'd1023, 8'h00, 8'h00, 8'h00});
    send_req('{lbr_pkg::REQ_READ, 10'd0, 10'd2, 8'h00, 8'h00, 8'h00});
    send_req('{lbr_pkg::REQ_READ, 10'd7, 10'd5, 8'h00, 8'h00, 8'h00});
    send_req('{lbr_pkg::REQ_READ, 10'd3, 10'd3, 8'h00, 8'h00, 8'h00});
    send_req('{lbr_pkg::REQ_READ, 10'd4, 10'd4, 8'h00, 8'h00, 8'h00});
    // Empty scaled area: every in-range read is border.
    set_sizes(11'd1024, 11'd1, 11'd1, 11'd1000, 8'd255);
    send_req('{lbr_pkg::REQ_READ, 10'd0, 10'd500, 8'h00, 8'h00, 8'h00});
    send_req('{lbr_pkg::REQ_READ, 10'd0, 10'd999, 8'h00, 8'h00, 8'h00});

    // Random phases, starting from the reset-like full-size setting.
    set_sizes(11'd640, 11'd640, 11'd640, 11'd640, 8'd114);
    fill_source();
    random_traffic(60);
    while (sent_count < TARGET_ITEMS) begin
      set_sizes(pick_src_size(), pick_src_size(), pick_dst_size(), pick_dst_size(),
                $urandom_range(0, 3) == 0 ? 8'd255 : 8'($urandom_range(0, 255)));
      fill_source();
      random_traffic(120);
    end

    drain();
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.expected_px.size() == 0)
      $display("letterbox_bilinear_image_resizer regression: pass");
    else
      $display("letterbox_bilinear_image_resizer regression: fail");
    $finish;
  end
endmodule
